>>> hdl/bb3_pkg.sv
// Shared types, constants and helper functions for the 3x3 box blur core.
// Used by every module of the block; depends on nothing else.
package bb3_pkg;

  // Default maximum image width and height.
  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int DEFAULT_MAX_HEIGHT = 1024;

  // Configuration register file.
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0]     DIM_RESET        = 11'd1024;

  // Request codes.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Job queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  // Reciprocal scaling for the rounding divide.
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 18;
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
  } out_item_t;

  // Window snapshot for one output pixel; center_right set when the center
  // column sits in window column 2 (right neighbours are not present).
  typedef struct packed {
    logic [8:0][23:0] win;
    logic             center_right;
  } job_t;

  typedef enum logic {FR_IDLE, FR_WORK} front_state_t;

  // Width or height as used: zero acts as one, large values clip to the maximum.
  function automatic int eff_dim(logic [CFG_W-1:0] v, int maxv);
    int r;
    r = int'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

  // ceil(2^RECIP_SHIFT / (2*n)) for the neighbour counts that occur.
  function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    case (n)
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = 18'd131072;
    endcase
    return m;
  endfunction

  // Rounded mean (2*s + n) / (2*n) via reciprocal multiply.
  function automatic logic [7:0] round_mean(logic [SUM_W-1:0] s, logic [CNT_W-1:0] n);
    logic [SUM_W:0] x;
    logic [SUM_W+RECIP_W:0] p;
    x = {s, 1'b0} + (SUM_W+1)'(n);
    p = (SUM_W+RECIP_W+1)'(x) * (SUM_W+RECIP_W+1)'(recip(n));
    return p[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

endpackage

>>> hdl/box_blur_3x3_core.sv
// Top level of the 3x3 edge-clipped box blur: configuration registers,
// front end, job queue and back end. Uses bb3_pkg, bb3_front, bb3_queue, bb3_back.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   input   | in_valid, in_stall, in_data     | pixels and drain requests in
//   output  | out_valid, out_stall, out_data  | blurred pixels out
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes in
//
// An input transaction that is taken occupies the front end: the line
// buffer is read on acceptance, then the window shifts and the line buffer
// is written. A job from the queue has its sums registered, then its rounded
// means (sum, divide), before it is presented. Reset is synchronous; the line
// buffers are not cleared. A stalled output backs up into the queue. The
// input stalls while a taken transaction is in work and while the queue is full.
module box_blur_3x3_core #(
  parameter int MAX_WIDTH  = bb3_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bb3_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bb3_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]        cfg_data
);
  import bb3_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic             restart;
  logic             push, pop, q_room, q_not_empty;
  job_t             push_job, q_head;

  assign cfg_ready = 1'b1;
  assign w_eff     = WW'(eff_dim(image_width, MAX_WIDTH));
  assign h_eff     = HW'(eff_dim(image_height, MAX_HEIGHT));

  // Register decode; a write to a known register restarts the frame.
  always_comb begin
    restart = 1'b0;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  restart = 1'b1;
        REG_IMAGE_HEIGHT: restart = 1'b1;
        default:          restart = 1'b0;
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  bb3_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_room  (q_room),
    .push    (push),
    .push_job(push_job)
  );

  bb3_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .room     (q_room),
    .pop      (pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  bb3_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> hdl/bb3_queue.sv
// Two-entry job queue between the front and the back of the blur core.
// Depends on bb3_pkg for the job type and depth.
module bb3_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bb3_pkg::job_t push_job,
  output logic          room,
  input  logic          pop,
  output logic          not_empty,
  output bb3_pkg::job_t head
);
  import bb3_pkg::*;

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign room      = count < (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

>>> hdl/bb3_front.sv
// Front end: accepts stream transactions, tracks the input position, keeps
// the line buffers and the 3x3 window, and issues blur jobs. Uses bb3_pkg.
module bb3_front #(
  parameter int MAX_WIDTH  = bb3_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    w_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   h_eff,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bb3_pkg::in_item_t                 in_data,
  input  logic                              q_room,
  output logic                              push,
  output bb3_pkg::job_t                     push_job
);
  import bb3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT+2);

  front_state_t     state, state_next;
  logic [AW-1:0]    col;
  logic [RW-1:0]    row;
  logic [8:0][23:0] win;
  logic [8:0][23:0] win_shift;
  logic [23:0]      pix_hold;
  logic [AW-1:0]    c_hold;
  logic [47:0]      mem [MAX_WIDTH];
  logic [47:0]      rd_q;

  logic          accept;
  logic          pixel_phase;
  logic          take;
  logic [AW-1:0] c_eff;
  logic          in_frame;
  logic          emit_prev;
  logic          emit_cur;
  logic          col_wrap;

  // Classify the offered transaction.
  assign in_stall    = !(state == FR_IDLE && q_room);
  assign accept      = in_valid && !in_stall;
  assign pixel_phase = 32'(row) < 32'(h_eff);
  assign take        = accept && ((in_data.req_type == REQ_DRAIN) != pixel_phase);
  assign c_eff       = (32'(col) >= 32'(w_eff)) ? '0 : col;

  // Window update and job selection for the item in work.
  always_comb begin
    win_shift = win;
    for (int k = 0; k < 3; k++) begin
      win_shift[k*3+0] = win[k*3+1];
      win_shift[k*3+1] = win[k*3+2];
    end
    win_shift[2] = rd_q[47:24];
    win_shift[5] = rd_q[23:0];
    win_shift[8] = pix_hold;
  end

  assign in_frame  = 32'(row) <= 32'(h_eff);
  assign emit_prev = (c_hold == '0) && (32'(row) >= 32'd2);
  assign emit_cur  = in_frame && (c_hold != '0) && (32'(row) >= 32'd1);
  assign col_wrap  = (32'(c_hold) + 32'd1) >= 32'(w_eff);

  assign push                  = (state == FR_WORK) && (emit_prev || emit_cur);
  assign push_job.win          = emit_prev ? win : win_shift;
  assign push_job.center_right = emit_prev;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (take) begin
          state_next = FR_WORK;
        end
      end
      FR_WORK: begin
        state_next = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  // State, position and window registers.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= FR_IDLE;
      col   <= '0;
      row   <= '0;
      win   <= '0;
    end else begin
      state <= state_next;
      if (state == FR_WORK) begin
        if (in_frame) begin
          win <= win_shift;
          if (col_wrap) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= c_hold + 1'b1;
          end
        end else begin
          win <= '0;
          col <= '0;
          row <= '0;
        end
      end
    end
  end

  // Held payload and line buffer memory ({upper, middle} per column).
  always_ff @(posedge clk) begin
    if (take) begin
      pix_hold <= (in_data.req_type == REQ_DRAIN) ? 24'd0 :
                  {in_data.pixel_red, in_data.pixel_green, in_data.pixel_blue};
      c_hold   <= c_eff;
      rd_q     <= mem[c_eff];
    end
    if (state == FR_WORK && in_frame) begin
      mem[c_hold] <= {rd_q[23:0], pix_hold};
    end
  end

endmodule

>>> hdl/bb3_back.sv
// Back end: takes blur jobs, sums the in-image neighbours, divides with
// rounding and presents the output transaction. Uses bb3_pkg.
module bb3_back #(
  parameter int MAX_WIDTH  = bb3_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    w_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   h_eff,
  input  logic                              q_not_empty,
  input  bb3_pkg::job_t                     q_head,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bb3_pkg::out_item_t                out_data
);
  import bb3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT+1);

  logic [AW-1:0]    out_col;
  logic [HW-1:0]    out_row;
  logic [8:0]       nb_ok;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  logic [CNT_W-1:0] nb_cnt;
  logic             is_last;

  logic             s1_valid;
  logic [SUM_W-1:0] s1_r, s1_g, s1_b;
  logic [CNT_W-1:0] s1_n;
  logic             s1_last;
  logic             s2_valid;
  out_item_t        s2_data;
  logic             s2_load;
  logic             out_take;

  // Neighbour mask from the output position and window alignment.
  always_comb begin
    logic row_up, row_dn, col_lf, col_rt;
    row_up = out_row != '0;
    row_dn = (32'(out_row) + 32'd1) < 32'(h_eff);
    col_lf = out_col != '0;
    col_rt = ((32'(out_col) + 32'd1) < 32'(w_eff)) && !q_head.center_right;
    for (int k = 0; k < 3; k++) begin
      logic row_ok;
      row_ok = (k == 0) ? row_up : ((k == 2) ? row_dn : 1'b1);
      if (q_head.center_right) begin
        nb_ok[k*3+0] = 1'b0;
        nb_ok[k*3+1] = row_ok && col_lf;
        nb_ok[k*3+2] = row_ok;
      end else begin
        nb_ok[k*3+0] = row_ok && col_lf;
        nb_ok[k*3+1] = row_ok;
        nb_ok[k*3+2] = row_ok && col_rt;
      end
    end
  end

  // Channel sums over the selected neighbours.
  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int i = 0; i < 9; i++) begin
      if (nb_ok[i]) begin
        sum_r = sum_r + SUM_W'(q_head.win[i][23:16]);
        sum_g = sum_g + SUM_W'(q_head.win[i][15:8]);
        sum_b = sum_b + SUM_W'(q_head.win[i][7:0]);
      end
    end
    nb_cnt  = CNT_W'($countones(nb_ok));
    is_last = (32'(out_row) + 32'd1 == 32'(h_eff)) &&
              (32'(out_col) + 32'd1 == 32'(w_eff));
  end

  // Pipeline flow control.
  assign out_take  = s2_valid && !out_stall;
  assign s2_load   = s1_valid && (!s2_valid || !out_stall);
  assign pop       = q_not_empty && (!s1_valid || s2_load);
  assign out_valid = s2_valid;
  assign out_data  = s2_data;

  // Control registers: stage valids and output position.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_col  <= '0;
      out_row  <= '0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (out_take) begin
        s2_valid <= 1'b0;
      end
      if (restart) begin
        out_col <= '0;
        out_row <= '0;
      end else if (pop) begin
        if (is_last) begin
          out_col <= '0;
          out_row <= '0;
        end else if ((32'(out_col) + 32'd1) >= 32'(w_eff)) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  // Payload registers: sums, then rounded means.
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_r    <= sum_r;
      s1_g    <= sum_g;
      s1_b    <= sum_b;
      s1_n    <= nb_cnt;
      s1_last <= is_last;
    end
    if (s2_load) begin
      s2_data.out_red    <= round_mean(s1_r, s1_n);
      s2_data.out_green  <= round_mean(s1_g, s1_n);
      s2_data.out_blue   <= round_mean(s1_b, s1_n);
      s2_data.frame_last <= s1_last;
    end
  end

endmodule
